### rtl/mns_pkg.sv
// Shared types and constants for the melody note sequencer.
// Used by every module of the block; no dependencies.
package mns_pkg;

  // Note table depth and field widths
  localparam int MAX_NOTES = 256;
  localparam int SLOT_W    = $clog2(MAX_NOTES);
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 8;
  localparam int POS_W     = 9;
  localparam int FREQ_W    = 16;
  localparam int DUR_W     = 8;
  localparam int SPEED_W   = 16;
  localparam int PRE_W     = 17;
  localparam int RELOAD_W  = 22;
  localparam int BASE_W    = 14;

  // Shared divider: 22-bit dividend, 16-bit divisor, one quotient bit a cycle
  localparam int DIV_W     = 22;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Saturated reload for a zero duration or zero speed
  localparam logic [RELOAD_W-1:0] RELOAD_SAT    = 22'd2560000;
  // 80 MHz timer clock over the 1000 prescale step
  localparam logic [DIV_W-1:0]    TONE_CLOCK_K  = 22'd80000;
  // Delay timer numerator
  localparam logic [DIV_W-1:0]    RELOAD_BASE_K = 22'd10000;

  // Input commands; codes 6 and 7 are ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_REPEAT = 3'd3,
    CMD_ENABLE = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_t;

  // Operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_BASE     = 2'd0,
    DIV_PRESCALE = 2'd1,
    DIV_SILENCE  = 2'd2
  } div_sel_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_EXEC      = 3'd1,
    ST_BASE_GO   = 3'd2,
    ST_BASE_WAIT = 3'd3,
    ST_NEXT_GO   = 3'd4,
    ST_NEXT_WAIT = 3'd5,
    ST_PUSH      = 3'd6
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch;
    logic     exec;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_base;
    logic     commit;
    logic     push;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tick_go;
    logic tone_phase;
    logic div_busy;
  } dp_status_t;

endpackage

### rtl/mns_div.sv
// Restoring divider, one quotient bit per cycle, a DIV_W-bit quotient per division.
// Depends on mns_pkg.
module mns_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic [mns_pkg::DIV_W-1:0]      dividend_i,
  input  logic [mns_pkg::SPEED_W-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [mns_pkg::DIV_W-1:0]      quotient_o
);

  logic [mns_pkg::DIV_W-1:0]     q_r, q_nxt;
  logic [mns_pkg::SPEED_W-1:0]   rem_r, rem_nxt;
  logic [mns_pkg::SPEED_W-1:0]   dsr_r, dsr_nxt;
  logic [mns_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [mns_pkg::SPEED_W:0]     rem_sh;
  logic [mns_pkg::SPEED_W:0]     diff;
  logic                          ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem_r, q_r[mns_pkg::DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    ge     = (rem_sh >= {1'b0, dsr_r});
  end

  // Load operands on start, otherwise advance one bit while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start_i) begin
      q_nxt    = dividend_i;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
      cnt_nxt  = mns_pkg::DIV_CNT_W'(mns_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[mns_pkg::DIV_W-2:0], ge};
      rem_nxt  = ge ? diff[mns_pkg::SPEED_W-1:0] : rem_sh[mns_pkg::SPEED_W-1:0];
      cnt_nxt  = cnt_r - mns_pkg::DIV_CNT_W'(1);
      busy_nxt = (cnt_r != mns_pkg::DIV_CNT_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy_o     = busy_r;
  assign quotient_o = q_r;

endmodule

### rtl/mns_dpath.sv
// Datapath: note tables, song state, shared divider and output register.
// Depends on mns_pkg and mns_div; driven by mns_ctrl commands.
module mns_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mns_pkg::ctrl_cmd_t              cmd_i,
  output mns_pkg::dp_status_t             status_o,
  input  logic [mns_pkg::CMD_W-1:0]       in_command,
  input  logic [mns_pkg::IDX_W-1:0]       in_note_index,
  input  logic [mns_pkg::FREQ_W-1:0]      in_note_freq,
  input  logic [mns_pkg::DUR_W-1:0]       in_note_duration,
  input  logic [mns_pkg::POS_W-1:0]       in_song_length,
  input  logic [mns_pkg::SPEED_W-1:0]     in_speed,
  input  logic                            in_flag_value,
  output logic                            out_tone_on,
  output logic [mns_pkg::PRE_W-1:0]       out_prescaler,
  output logic [mns_pkg::RELOAD_W-1:0]    out_delay_reload,
  output logic                            out_reload_written,
  output logic                            out_timer_running
);

  // Latched item
  logic [mns_pkg::CMD_W-1:0]    lat_cmd_r;
  logic [mns_pkg::IDX_W-1:0]    lat_idx_r;
  logic [mns_pkg::FREQ_W-1:0]   lat_freq_r;
  logic [mns_pkg::DUR_W-1:0]    lat_dur_r;
  logic [mns_pkg::POS_W-1:0]    lat_len_r;
  logic [mns_pkg::SPEED_W-1:0]  lat_spd_r;
  logic                         lat_flag_r;

  // Note tables and their registered read data
  logic [mns_pkg::FREQ_W-1:0]   freq_mem [mns_pkg::MAX_NOTES];
  logic [mns_pkg::DUR_W-1:0]    dur_mem  [mns_pkg::MAX_NOTES];
  logic [mns_pkg::FREQ_W-1:0]   f_rd_r;
  logic [mns_pkg::DUR_W-1:0]    d_rd_r;
  logic                         mem_we;
  logic [mns_pkg::SLOT_W-1:0]   rd_addr;

  // Song state
  logic [mns_pkg::POS_W-1:0]    position_r, position_nxt;
  logic [mns_pkg::POS_W-1:0]    song_len_r, song_len_nxt;
  logic [mns_pkg::SPEED_W-1:0]  speed_r, speed_nxt;
  logic                         playing_r, playing_nxt;
  logic                         tone_phase_r, tone_phase_nxt;
  logic                         repeat_r, repeat_nxt;
  logic                         enabled_r, enabled_nxt;
  logic                         duty_r, duty_nxt;
  logic [mns_pkg::PRE_W-1:0]    prescaler_r, prescaler_nxt;
  logic [mns_pkg::RELOAD_W-1:0] reload_r, reload_nxt;
  logic                         written_r, written_nxt;
  logic [mns_pkg::BASE_W-1:0]   base_r, base_nxt;

  // Divider hookup
  logic [mns_pkg::DIV_W-1:0]    div_dividend;
  logic [mns_pkg::SPEED_W-1:0]  div_divisor;
  logic                         div_busy;
  logic [mns_pkg::DIV_W-1:0]    div_quot;

  logic                         at_end;

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      lat_cmd_r  <= in_command;
      lat_idx_r  <= in_note_index;
      lat_freq_r <= in_note_freq;
      lat_dur_r  <= in_note_duration;
      lat_len_r  <= in_song_length;
      lat_spd_r  <= in_speed;
      lat_flag_r <= in_flag_value;
    end
  end

  // End of song: wrap reads slot 0, otherwise the current slot
  assign at_end  = (position_r == song_len_r);
  assign rd_addr = at_end ? '0 : position_r[mns_pkg::SLOT_W-1:0];
  assign mem_we  = cmd_i.exec && (lat_cmd_r == mns_pkg::CMD_LOAD) &&
                   (32'(lat_idx_r) < mns_pkg::MAX_NOTES);

  // Note tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      freq_mem[lat_idx_r[mns_pkg::SLOT_W-1:0]] <= lat_freq_r;
      dur_mem[lat_idx_r[mns_pkg::SLOT_W-1:0]]  <= lat_dur_r;
    end
    f_rd_r <= freq_mem[rd_addr];
    d_rd_r <= dur_mem[rd_addr];
  end

  // Select divider operands
  always_comb begin
    case (cmd_i.div_sel)
      mns_pkg::DIV_BASE: begin
        div_dividend = mns_pkg::RELOAD_BASE_K;
        div_divisor  = {{(mns_pkg::SPEED_W-mns_pkg::DUR_W){1'b0}}, d_rd_r};
      end
      mns_pkg::DIV_PRESCALE: begin
        div_dividend = mns_pkg::TONE_CLOCK_K;
        div_divisor  = f_rd_r;
      end
      mns_pkg::DIV_SILENCE: begin
        div_dividend = mns_pkg::DIV_W'({base_r, 8'd0});
        div_divisor  = speed_r;
      end
      default: begin
        div_dividend = mns_pkg::RELOAD_BASE_K;
        div_divisor  = {{(mns_pkg::SPEED_W-mns_pkg::DUR_W){1'b0}}, d_rd_r};
      end
    endcase
  end

  mns_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Song state updates for command execution and tick commit
  always_comb begin
    position_nxt   = position_r;
    song_len_nxt   = song_len_r;
    speed_nxt      = speed_r;
    playing_nxt    = playing_r;
    tone_phase_nxt = tone_phase_r;
    repeat_nxt     = repeat_r;
    enabled_nxt    = enabled_r;
    duty_nxt       = duty_r;
    prescaler_nxt  = prescaler_r;
    reload_nxt     = reload_r;
    written_nxt    = written_r;
    base_nxt       = base_r;

    if (cmd_i.exec) begin
      written_nxt = 1'b0;
      case (lat_cmd_r)
        mns_pkg::CMD_PLAY: begin
          if (enabled_r && (lat_len_r != '0) && (lat_spd_r != '0)) begin
            playing_nxt    = 1'b1;
            tone_phase_nxt = 1'b1;
            position_nxt   = '0;
            speed_nxt      = lat_spd_r;
            repeat_nxt     = 1'b0;
            // Clamp long songs to the table depth
            song_len_nxt   = (32'(lat_len_r) > mns_pkg::MAX_NOTES) ?
                             mns_pkg::POS_W'(mns_pkg::MAX_NOTES) : lat_len_r;
          end
        end
        mns_pkg::CMD_STOP: begin
          duty_nxt    = 1'b0;
          playing_nxt = 1'b0;
          repeat_nxt  = 1'b0;
        end
        mns_pkg::CMD_REPEAT: begin
          repeat_nxt = lat_flag_r;
        end
        mns_pkg::CMD_ENABLE: begin
          if (playing_r && !lat_flag_r) begin
            duty_nxt    = 1'b0;
            playing_nxt = 1'b0;
            repeat_nxt  = 1'b0;
          end
          enabled_nxt = lat_flag_r;
        end
        mns_pkg::CMD_TICK: begin
          // Wrap or stop at the end of the song
          if (playing_r && at_end) begin
            if (repeat_r) begin
              position_nxt = '0;
            end else begin
              duty_nxt    = 1'b0;
              playing_nxt = 1'b0;
              repeat_nxt  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.take_base) begin
      base_nxt = div_quot[mns_pkg::BASE_W-1:0];
    end

    if (cmd_i.commit) begin
      written_nxt = 1'b1;
      if (tone_phase_r) begin
        // Tone phase: drive duty unless a rest, load duration reload
        if (f_rd_r != '0) begin
          duty_nxt      = 1'b1;
          prescaler_nxt = div_quot[mns_pkg::PRE_W-1:0];
        end else begin
          duty_nxt = 1'b0;
        end
        reload_nxt     = (d_rd_r != '0) ?
                         mns_pkg::RELOAD_W'(base_r) : mns_pkg::RELOAD_SAT;
        tone_phase_nxt = 1'b0;
      end else begin
        // Silence phase: scaled reload, advance to the next note
        duty_nxt       = 1'b0;
        reload_nxt     = ((d_rd_r == '0) || (speed_r == '0)) ?
                         mns_pkg::RELOAD_SAT : div_quot[mns_pkg::RELOAD_W-1:0];
        position_nxt   = position_r + mns_pkg::POS_W'(1);
        tone_phase_nxt = 1'b1;
      end
    end
  end

  // Song state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      song_len_r   <= '0;
      speed_r      <= '0;
      playing_r    <= 1'b0;
      tone_phase_r <= 1'b1;
      repeat_r     <= 1'b0;
      enabled_r    <= 1'b1;
      duty_r       <= 1'b0;
      prescaler_r  <= '0;
      reload_r     <= '0;
      written_r    <= 1'b0;
    end else begin
      position_r   <= position_nxt;
      song_len_r   <= song_len_nxt;
      speed_r      <= speed_nxt;
      playing_r    <= playing_nxt;
      tone_phase_r <= tone_phase_nxt;
      repeat_r     <= repeat_nxt;
      enabled_r    <= enabled_nxt;
      duty_r       <= duty_nxt;
      prescaler_r  <= prescaler_nxt;
      reload_r     <= reload_nxt;
      written_r    <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
  end

  // Output register, loaded when the controller pushes a result
  always_ff @(posedge clk) begin
    if (cmd_i.push) begin
      out_tone_on        <= duty_r;
      out_prescaler      <= prescaler_r;
      out_delay_reload   <= reload_r;
      out_reload_written <= written_r;
      out_timer_running  <= playing_r;
    end
  end

  // Status to the controller
  always_comb begin
    status_o.tick_go    = (lat_cmd_r == mns_pkg::CMD_TICK) && playing_r &&
                          (!at_end || repeat_r);
    status_o.tone_phase = tone_phase_r;
    status_o.div_busy   = div_busy;
  end

endmodule

### rtl/mns_ctrl.sv
// Controller state machine: sequences execution, divisions and result push.
// Depends on mns_pkg; commands mns_dpath.
module mns_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mns_pkg::dp_status_t  status_i,
  output mns_pkg::ctrl_cmd_t   cmd_o
);

  mns_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    in_ready      = 1'b0;
    // Drop the result once it is transferred
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      mns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          state_nxt   = mns_pkg::ST_EXEC;
        end
      end
      mns_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_nxt  = status_i.tick_go ? mns_pkg::ST_BASE_GO : mns_pkg::ST_PUSH;
      end
      mns_pkg::ST_BASE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = mns_pkg::DIV_BASE;
        state_nxt       = mns_pkg::ST_BASE_WAIT;
      end
      mns_pkg::ST_BASE_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.take_base = 1'b1;
          state_nxt       = mns_pkg::ST_NEXT_GO;
        end
      end
      mns_pkg::ST_NEXT_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = status_i.tone_phase ? mns_pkg::DIV_PRESCALE :
                                                mns_pkg::DIV_SILENCE;
        state_nxt       = mns_pkg::ST_NEXT_WAIT;
      end
      mns_pkg::ST_NEXT_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.commit = 1'b1;
          state_nxt    = mns_pkg::ST_PUSH;
        end
      end
      mns_pkg::ST_PUSH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd_o.push    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mns_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mns_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/melody_note_sequencer.sv
// Melody note sequencer for a PWM buzzer: top level.
// Depends on mns_pkg, mns_ctrl and mns_dpath (which holds mns_div).
//
// Usage:
//   The input channel (in_valid/in_ready) takes one command per transfer:
//   load note, play, stop, set repeat, set enable or tick. Every command
//   yields exactly one result on the output channel (out_valid/out_ready)
//   showing duty, prescaler, delay reload, whether the reload was written
//   and whether a song is running, all as they stand after the command.
//   Timing: non-tick commands and ticks that do nothing pass through the
//   execute and push states, and out_valid rises in the same cycle that
//   in_ready is high again. A tick that plays a phase runs two divisions
//   on one shared restoring divider, each started in a go state and taken
//   in a wait state once the divider is no longer busy; the result is then
//   pushed once the output register is free. One command is in work at a time.
//   The output register holds a result while the receiver stalls, and the
//   next command is taken meanwhile; its result waits for the register.
//   Reset (synchronous, active low) stops the song, enables the block and
//   clears the song state and out_valid; the note tables keep no reset
//   value and must be loaded before they are played.
module melody_note_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mns_pkg::CMD_W-1:0]       in_command,
  input  logic [mns_pkg::IDX_W-1:0]       in_note_index,
  input  logic [mns_pkg::FREQ_W-1:0]      in_note_freq,
  input  logic [mns_pkg::DUR_W-1:0]       in_note_duration,
  input  logic [mns_pkg::POS_W-1:0]       in_song_length,
  input  logic [mns_pkg::SPEED_W-1:0]     in_speed,
  input  logic                            in_flag_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_tone_on,
  output logic [mns_pkg::PRE_W-1:0]       out_prescaler,
  output logic [mns_pkg::RELOAD_W-1:0]    out_delay_reload,
  output logic                            out_reload_written,
  output logic                            out_timer_running
);

  mns_pkg::ctrl_cmd_t  ctrl_cmd;
  mns_pkg::dp_status_t dp_status;

  mns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  mns_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .in_command         (in_command),
    .in_note_index      (in_note_index),
    .in_note_freq       (in_note_freq),
    .in_note_duration   (in_note_duration),
    .in_song_length     (in_song_length),
    .in_speed           (in_speed),
    .in_flag_value      (in_flag_value),
    .out_tone_on        (out_tone_on),
    .out_prescaler      (out_prescaler),
    .out_delay_reload   (out_delay_reload),
    .out_reload_written (out_reload_written),
    .out_timer_running  (out_timer_running)
  );

endmodule

### rtl/mns_checker.sv
// Port-level checker for melody_note_sequencer, attached by bind.
// Depends on mns_pkg for port widths.
module mns_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_tone_on,
  input logic [mns_pkg::PRE_W-1:0]       out_prescaler,
  input logic [mns_pkg::RELOAD_W-1:0]    out_delay_reload,
  input logic                            out_reload_written,
  input logic                            out_timer_running
);

  // One command in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in work");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_delay_reload) &&
      $stable(out_prescaler) && $stable(out_tone_on))
    else $error("stalled result changed");

  // Duty is driven only while a song runs
  a_tone_needs_song: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_tone_on || out_timer_running)
    else $error("tone on with no song running");

  // A reload is written only by a tick of a running song
  a_reload_needs_song: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_reload_written || out_timer_running)
    else $error("reload written with no song running");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind melody_note_sequencer mns_checker u_mns_checker (.*);

### bench/tb.sv
// Testbench for melody_note_sequencer: directed and random command streams
// checked against an in-bench player model. Depends on mns_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  // Command codes the block ignores
  localparam logic [mns_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd6;
  localparam logic [mns_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
  localparam logic [mns_pkg::POS_W-1:0] SONG_MAX      =
    mns_pkg::POS_W'(mns_pkg::MAX_NOTES);
  localparam int                        ITEM_TARGET   = 750;
  localparam int                        SETTLE_CYCLES = 60;
  localparam int                        RUN_LIMIT_NS  = 2_000_000;

  typedef struct packed {
    logic [mns_pkg::CMD_W-1:0]   command;
    logic [mns_pkg::IDX_W-1:0]   note_index;
    logic [mns_pkg::FREQ_W-1:0]  note_freq;
    logic [mns_pkg::DUR_W-1:0]   note_duration;
    logic [mns_pkg::POS_W-1:0]   song_length;
    logic [mns_pkg::SPEED_W-1:0] speed;
    logic                        flag_value;
  } note_cmd_t;

  typedef struct packed {
    logic                         tone_on;
    logic [mns_pkg::PRE_W-1:0]    prescaler;
    logic [mns_pkg::RELOAD_W-1:0] delay_reload;
    logic                         reload_written;
    logic                         timer_running;
  } player_status_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [mns_pkg::CMD_W-1:0]    in_command;
  logic [mns_pkg::IDX_W-1:0]    in_note_index;
  logic [mns_pkg::FREQ_W-1:0]   in_note_freq;
  logic [mns_pkg::DUR_W-1:0]    in_note_duration;
  logic [mns_pkg::POS_W-1:0]    in_song_length;
  logic [mns_pkg::SPEED_W-1:0]  in_speed;
  logic                         in_flag_value;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_tone_on;
  logic [mns_pkg::PRE_W-1:0]    out_prescaler;
  logic [mns_pkg::RELOAD_W-1:0] out_delay_reload;
  logic                         out_reload_written;
  logic                         out_timer_running;

  melody_note_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_note_index      (in_note_index),
    .in_note_freq       (in_note_freq),
    .in_note_duration   (in_note_duration),
    .in_song_length     (in_song_length),
    .in_speed           (in_speed),
    .in_flag_value      (in_flag_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tone_on        (out_tone_on),
    .out_prescaler      (out_prescaler),
    .out_delay_reload   (out_delay_reload),
    .out_reload_written (out_reload_written),
    .out_timer_running  (out_timer_running)
  );

  always #1 clk = ~clk;

  // Player model state
  logic [mns_pkg::FREQ_W-1:0]   freq_slots [mns_pkg::MAX_NOTES];
  logic [mns_pkg::DUR_W-1:0]    dur_slots  [mns_pkg::MAX_NOTES];
  bit                           slot_loaded [mns_pkg::MAX_NOTES];
  logic [mns_pkg::POS_W-1:0]    note_pos;
  logic [mns_pkg::POS_W-1:0]    notes_in_song;
  logic [mns_pkg::SPEED_W-1:0]  tempo;
  bit                           song_active;
  bit                           in_tone_half;
  bit                           loop_song;
  bit                           player_enabled;
  bit                           buzz_on;
  logic [mns_pkg::PRE_W-1:0]    pwm_prescale;
  logic [mns_pkg::RELOAD_W-1:0] delay_count;

  player_status_t      expected_status [$];
  player_status_t      front_status;
  int                  mismatch_count;
  int                  accepted_items;
  int                  rx_hold_cycles;
  bit                  tx_steady;
  bit                  rx_steady;

  function automatic void reset_player();
    for (int i = 0; i < mns_pkg::MAX_NOTES; i++) slot_loaded[i] = 1'b0;
    note_pos       = '0;
    notes_in_song  = '0;
    tempo          = '0;
    song_active    = 1'b0;
    in_tone_half   = 1'b1;
    loop_song      = 1'b0;
    player_enabled = 1'b1;
    buzz_on        = 1'b0;
    pwm_prescale   = '0;
    delay_count    = '0;
  endfunction

  function automatic void stop_song();
    buzz_on     = 1'b0;
    song_active = 1'b0;
    loop_song   = 1'b0;
  endfunction

  // Advance the player by one command and return the status it shows
  function automatic player_status_t apply_command(input note_cmd_t c);
    player_status_t r;
    bit             wrote;
    bit             go;
    logic [31:0]    f;
    logic [31:0]    d;
    logic [31:0]    base;
    logic [31:0]    q;
    logic [mns_pkg::SLOT_W-1:0] slot;
    wrote = 1'b0;
    case (c.command)
      mns_pkg::CMD_LOAD: begin
        if (c.note_index < mns_pkg::MAX_NOTES) begin
          freq_slots[c.note_index]  = c.note_freq;
          dur_slots[c.note_index]   = c.note_duration;
          slot_loaded[c.note_index] = 1'b1;
        end
      end
      mns_pkg::CMD_PLAY: begin
        if (player_enabled && c.song_length != 0 && c.speed != 0) begin
          notes_in_song = (c.song_length > SONG_MAX) ? SONG_MAX : c.song_length;
          song_active   = 1'b1;
          in_tone_half  = 1'b1;
          note_pos      = '0;
          tempo         = c.speed;
          loop_song     = 1'b0;
        end
      end
      mns_pkg::CMD_STOP: stop_song();
      mns_pkg::CMD_REPEAT: loop_song = c.flag_value;
      mns_pkg::CMD_ENABLE: begin
        if (song_active && !c.flag_value) stop_song();
        player_enabled = c.flag_value;
      end
      mns_pkg::CMD_TICK: begin
        if (song_active) begin
          go = 1'b1;
          // wrap or finish at the end of the song
          if (note_pos == notes_in_song) begin
            if (loop_song) begin
              note_pos = '0;
            end else begin
              stop_song();
              go = 1'b0;
            end
          end
          if (go) begin
            slot = note_pos[mns_pkg::SLOT_W-1:0];
            f    = freq_slots[slot];
            d    = dur_slots[slot];
            base = (d != 0) ? 32'd10000 / d : 32'd0;
            if (in_tone_half) begin
              // tone half: rest keeps the old prescaler
              if (f != 0) begin
                buzz_on      = 1'b1;
                q            = (32'd80000000 / f) / 32'd1000;
                pwm_prescale = q[mns_pkg::PRE_W-1:0];
              end else begin
                buzz_on = 1'b0;
              end
              delay_count  = (d != 0) ? base[mns_pkg::RELOAD_W-1:0] :
                             mns_pkg::RELOAD_SAT;
              in_tone_half = 1'b0;
            end else begin
              // silence half: scale by speed, then step to the next note
              buzz_on = 1'b0;
              if (d == 0 || tempo == 0) begin
                delay_count = mns_pkg::RELOAD_SAT;
              end else begin
                q           = (base * 32'd256) / {16'd0, tempo};
                delay_count = q[mns_pkg::RELOAD_W-1:0];
              end
              note_pos     = note_pos + mns_pkg::POS_W'(1);
              in_tone_half = 1'b1;
            end
            wrote = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.tone_on        = buzz_on;
    r.prescaler      = pwm_prescale;
    r.delay_reload   = delay_count;
    r.reload_written = wrote;
    r.timer_running  = song_active;
    return r;
  endfunction

  // Report the slot a tick would read when that slot holds no note yet
  function automatic bit tick_hits_empty_slot(output logic [31:0] slot);
    logic [mns_pkg::POS_W-1:0] p;
    slot = '0;
    if (!song_active) return 1'b0;
    p = note_pos;
    if (p == notes_in_song) begin
      if (!loop_song) return 1'b0;
      p = '0;
    end
    slot = 32'(p[mns_pkg::SLOT_W-1:0]);
    return !slot_loaded[p[mns_pkg::SLOT_W-1:0]];
  endfunction

  function automatic note_cmd_t rand_cmd(input logic [mns_pkg::CMD_W-1:0] op);
    note_cmd_t   c;
    logic [31:0] r;
    c.command       = op;
    r = $urandom; c.note_index    = r[mns_pkg::IDX_W-1:0];
    r = $urandom; c.note_freq     = r[mns_pkg::FREQ_W-1:0];
    r = $urandom; c.note_duration = r[mns_pkg::DUR_W-1:0];
    r = $urandom; c.song_length   = r[mns_pkg::POS_W-1:0];
    r = $urandom; c.speed         = r[mns_pkg::SPEED_W-1:0];
    r = $urandom; c.flag_value    = r[0];
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Offer one command; record its expected status, hold until the transfer
  task automatic drive_item(input note_cmd_t c);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_status.push_back(apply_command(c));
    in_valid         <= 1'b1;
    in_command       <= c.command;
    in_note_index    <= c.note_index;
    in_note_freq     <= c.note_freq;
    in_note_duration <= c.note_duration;
    in_song_length   <= c.song_length;
    in_speed         <= c.speed;
    in_flag_value    <= c.flag_value;
    do @(posedge clk); while (!in_ready);
    accepted_items++;
  endtask

  // Load any note a tick is about to play before the tick goes out
  task automatic send_command(input note_cmd_t c);
    note_cmd_t   fill;
    logic [31:0] slot;
    if (c.command == mns_pkg::CMD_TICK && tick_hits_empty_slot(slot)) begin
      fill            = rand_cmd(mns_pkg::CMD_LOAD);
      fill.note_index = slot[mns_pkg::IDX_W-1:0];
      drive_item(fill);
    end
    drive_item(c);
  endtask

  task automatic send_load(input logic [31:0] slot, input logic [31:0] freq,
                           input logic [31:0] dur);
    note_cmd_t c;
    c               = rand_cmd(mns_pkg::CMD_LOAD);
    c.note_index    = slot[mns_pkg::IDX_W-1:0];
    c.note_freq     = freq[mns_pkg::FREQ_W-1:0];
    c.note_duration = dur[mns_pkg::DUR_W-1:0];
    send_command(c);
  endtask

  task automatic send_play(input logic [31:0] len, input logic [31:0] spd);
    note_cmd_t c;
    c             = rand_cmd(mns_pkg::CMD_PLAY);
    c.song_length = len[mns_pkg::POS_W-1:0];
    c.speed       = spd[mns_pkg::SPEED_W-1:0];
    send_command(c);
  endtask

  task automatic send_op(input logic [mns_pkg::CMD_W-1:0] op, input logic flag);
    note_cmd_t c;
    c            = rand_cmd(op);
    c.flag_value = flag;
    send_command(c);
  endtask

  // Release the input so the last command is not taken twice, then drain
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // Field extremes: fastest and slowest notes and a rest with zero duration,
  // then the song running off its end
  task automatic test_note_extremes();
    send_load(0, 1, 1);
    send_load(1, 65535, 255);
    send_load(2, 0, 0);
    send_load(3, 80001, 128);
    send_play(4, 16'h0001);
    repeat (9) send_op(mns_pkg::CMD_TICK, 1'b0);
    send_op(mns_pkg::CMD_TICK, 1'b1);
  endtask

  // Play refused when disabled, at zero length or zero speed; unused codes
  task automatic test_refused_play();
    send_op(mns_pkg::CMD_ENABLE, 1'b0);
    send_play(3, 16'h0100);
    send_op(mns_pkg::CMD_ENABLE, 1'b1);
    send_play(0, 16'h0100);
    send_play(2, 0);
    send_op(CMD_SPARE_LO, 1'b1);
    send_op(CMD_SPARE_HI, 1'b0);
    send_op(mns_pkg::CMD_STOP, 1'b1);
  endtask

  // Repeat wrap, restart while playing, long song clamp, disable mid-song
  task automatic test_repeat_and_restart();
    send_play(2, 16'hFFFF);
    send_op(mns_pkg::CMD_REPEAT, 1'b1);
    repeat (5) send_op(mns_pkg::CMD_TICK, 1'b1);
    send_play(300, 16'h0100);
    send_op(mns_pkg::CMD_TICK, 1'b0);
    send_op(mns_pkg::CMD_ENABLE, 1'b0);
    send_op(mns_pkg::CMD_ENABLE, 1'b1);
  endtask

  // Hold the result side off while commands keep coming, then drain
  task automatic test_output_stall();
    rx_hold_cycles = 300;
    tx_steady      = 1'b1;
    send_load(0, 440, 4);
    send_load(1, 0, 8);
    send_load(2, 2000, 0);
    send_play(3, 16'h0200);
    send_op(mns_pkg::CMD_REPEAT, 1'b1);
    repeat (10) send_op(mns_pkg::CMD_TICK, 1'b0);
    tx_steady = 1'b0;
    wait_all_results();
  endtask

  // Mostly well-formed songs with random notes, mixed with noise commands
  task automatic test_random_songs();
    int unsigned notes;
    int unsigned ticks;
    logic [31:0] freq;
    logic [31:0] dur;
    logic [31:0] len;
    logic [31:0] spd;
    logic [31:0] r;
    while (accepted_items < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if (!player_enabled) send_op(mns_pkg::CMD_ENABLE, 1'b1);
        notes = $urandom_range(1, 6);
        for (int i = 0; i < notes; i++) begin
          case ($urandom_range(0, 5))
            0:       freq = 0;
            1:       freq = $urandom_range(1, 100);
            2:       freq = $urandom_range(60000, 65535);
            default: freq = $urandom_range(0, 65535);
          endcase
          dur = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
          send_load(i, freq, dur);
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : notes;
        case ($urandom_range(0, 9))
          0:       spd = $urandom_range(0, 65535);
          1:       spd = 16'h0100;
          default: spd = $urandom_range(1, 65535);
        endcase
        send_play(len, spd);
        if ($urandom_range(0, 1) == 0) send_op(mns_pkg::CMD_REPEAT, 1'b1);
        ticks = 2 * notes + $urandom_range(0, 6);
        for (int t = 0; t < ticks; t++) begin
          if ($urandom_range(0, 14) == 0) begin
            r = $urandom;
            send_command(rand_cmd(r[mns_pkg::CMD_W-1:0]));
          end else begin
            send_command(rand_cmd(mns_pkg::CMD_TICK));
          end
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          r = $urandom;
          send_command(rand_cmd(r[mns_pkg::CMD_W-1:0]));
        end
      end
      if ($urandom_range(0, 15) == 0) wait_all_results();
    end
  endtask

  // Drain results with random stalls and optional long hold-off
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("result transfer with no expected status pending");
        mismatch_count++;
      end else begin
        front_status = expected_status.pop_front();
        check_field("tone_on", 32'(front_status.tone_on), 32'(out_tone_on));
        check_field("prescaler", 32'(front_status.prescaler), 32'(out_prescaler));
        check_field("delay_reload", 32'(front_status.delay_reload),
                    32'(out_delay_reload));
        check_field("reload_written", 32'(front_status.reload_written),
                    32'(out_reload_written));
        check_field("timer_running", 32'(front_status.timer_running),
                    32'(out_timer_running));
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = mns_pkg::CMD_LOAD;
    in_note_index    = '0;
    in_note_freq     = '0;
    in_note_duration = '0;
    in_song_length   = '0;
    in_speed         = '0;
    in_flag_value    = 1'b0;
    out_ready        = 1'b0;
    mismatch_count   = 0;
    accepted_items   = 0;
    rx_hold_cycles   = 0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    reset_player();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_note_extremes();
    test_refused_play();
    test_repeat_and_restart();
    test_output_stall();
    test_random_songs();

    // Drain, then let the block settle
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
